>>> rtl/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types and constants of the antialiased subpixel plotter: the
// operation codes, the default matrix size and the pixel operation that
// travels from the front end to the frame store.
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int MATRIX_WIDTH_DEF  = 16;
  localparam int MATRIX_HEIGHT_DEF = 16;

  // 16 address bits cover a matrix of up to 256 by 256 pixels.
  localparam int ADDR_W_MAX = 16;

  typedef enum logic {
    OP_PLOT = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_PLOT,
    FS_READ
  } front_state_t;

  typedef struct packed {
    op_t                   kind;
    logic                  hit;
    logic [ADDR_W_MAX-1:0] addr;
    logic [7:0]            weight;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
  } pixel_op_t;

endpackage

>>> rtl/asp_in_if.sv
// ----------------------------------------------------------------------------
// asp_in_if
// Request channel of the plotter: one beat is a plot or a read item.
// ----------------------------------------------------------------------------
interface asp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [7:0]  pixel_index;

  modport source (
    output valid, operation, pos_x, pos_y, red_in, green_in, blue_in, pixel_index,
    input  ready
  );

  modport sink (
    input  valid, operation, pos_x, pos_y, red_in, green_in, blue_in, pixel_index,
    output ready
  );
endinterface

>>> rtl/asp_out_if.sv
// ----------------------------------------------------------------------------
// asp_out_if
// Response channel of the plotter: one beat is the color of a read pixel.
// ----------------------------------------------------------------------------
interface asp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

>>> rtl/asp_front.sv
// ----------------------------------------------------------------------------
// asp_front
// Front end: accepts request beats, works out the four bilinear weights and
// neighbor addresses of a plot one neighbor per cycle while the queue is not
// full, drops neighbors that fall outside the matrix, and queues one pixel op per update or read.
// ----------------------------------------------------------------------------
module asp_front
  import asp_pkg::*;
#(
  parameter int MATRIX_WIDTH  = MATRIX_WIDTH_DEF,
  parameter int MATRIX_HEIGHT = MATRIX_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  asp_in_if.sink    req,
  input  logic      clear_busy,
  input  logic      q_full,
  output logic      q_push,
  output pixel_op_t q_data
);

  localparam int PIXELS = MATRIX_WIDTH * MATRIX_HEIGHT;

  front_state_t state;
  front_state_t state_next;
  logic [1:0]   step;

  logic [7:0] frac_x;
  logic [7:0] frac_y;
  logic [3:0] col_base;
  logic [3:0] row_base;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] index;

  logic        accept;
  logic        advance;
  logic        last;
  logic [4:0]  col;
  logic [4:0]  row;
  logic        inside_matrix;
  logic [16:0] linear;
  logic [7:0]  wa;
  logic [7:0]  wb;
  logic [15:0] wsum;

  always_comb begin
    col           = {1'b0, col_base} + {4'b0, step[0]};
    row           = {1'b0, row_base} + {4'b0, step[1]};
    inside_matrix = (32'(col) < MATRIX_WIDTH) && (32'(row) < MATRIX_HEIGHT);
    linear        = 17'(17'(row) * 17'(MATRIX_WIDTH)) + 17'(col);
    wa            = step[0] ? frac_x : 8'(8'hff - frac_x);
    wb            = step[1] ? frac_y : 8'(8'hff - frac_y);
    wsum          = 16'(16'(wa) * 16'(wb)) + 16'(wa) + 16'(wb);
  end

  always_comb begin
    q_push  = 1'b0;
    advance = 1'b0;
    last    = 1'b0;
    q_data  = '0;
    case (state)
      FS_PLOT: begin
        q_push  = inside_matrix && !q_full;
        advance = !inside_matrix || !q_full;
        last    = advance && (step == 2'd3);
        q_data.kind   = OP_PLOT;
        q_data.hit    = 1'b1;
        q_data.addr   = linear[ADDR_W_MAX-1:0];
        q_data.weight = wsum[15:8];
        q_data.red    = red;
        q_data.green  = green;
        q_data.blue   = blue;
      end
      FS_READ: begin
        q_push  = !q_full;
        advance = !q_full;
        last    = advance;
        q_data.kind = OP_READ;
        q_data.hit  = 32'(index) < PIXELS;
        q_data.addr = ADDR_W_MAX'(index);
      end
      default: begin
      end
    endcase
    req.ready = !clear_busy && ((state == FS_IDLE) || last);
    accept    = req.valid && req.ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE, FS_PLOT, FS_READ: begin
        if (accept) begin
          state_next = (op_t'(req.operation) == OP_READ) ? FS_READ : FS_PLOT;
        end else if (last) begin
          state_next = FS_IDLE;
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= '0;
      end else if (advance) begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frac_x   <= req.pos_x[7:0];
      frac_y   <= req.pos_y[7:0];
      col_base <= req.pos_x[11:8];
      row_base <= req.pos_y[11:8];
      red      <= req.red_in;
      green    <= req.green_in;
      blue     <= req.blue_in;
      index    <= req.pixel_index;
    end
  end

endmodule

>>> rtl/asp_queue.sv
// ----------------------------------------------------------------------------
// asp_queue
// Two-entry queue of pixel operations between the front end and the frame
// store.
// ----------------------------------------------------------------------------
module asp_queue
  import asp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pixel_op_t push_data,
  output logic      full,
  input  logic      pop,
  output pixel_op_t pop_data,
  output logic      empty
);

  pixel_op_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/asp_back.sv
// ----------------------------------------------------------------------------
// asp_back
// Back end: owns the frame store, clears it after reset, and carries out one
// pixel operation per cycle (a read waits while its response is held) as a
// registered read followed by a scaled, saturating add and write, or by a read response beat.
// ----------------------------------------------------------------------------
module asp_back
  import asp_pkg::*;
#(
  parameter int MATRIX_WIDTH  = MATRIX_WIDTH_DEF,
  parameter int MATRIX_HEIGHT = MATRIX_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  asp_out_if.source rsp,
  output logic      clear_busy,
  input  logic      q_empty,
  input  pixel_op_t q_data,
  output logic      q_pop
);

  localparam int PIXELS = MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int PIX_AW = $clog2(PIXELS);

  logic [23:0] mem [PIXELS];

  logic [PIX_AW-1:0] clear_addr;
  logic              s1_valid;
  pixel_op_t         s1;
  logic [23:0]       rdata;
  logic              fwd;
  logic [23:0]       fwd_data;

  logic              s1_advance;
  logic              wr_en;
  logic [PIX_AW-1:0] wr_addr;
  logic [23:0]       wr_data;
  logic [PIX_AW-1:0] rd_addr;
  logic [23:0]       pix;
  logic [15:0]       prod_r;
  logic [15:0]       prod_g;
  logic [15:0]       prod_b;
  logic [8:0]        sum_r;
  logic [8:0]        sum_g;
  logic [8:0]        sum_b;

  always_comb begin
    s1_advance = s1_valid && ((s1.kind == OP_PLOT) || !rsp.valid || rsp.ready);
    q_pop      = !q_empty && !clear_busy && (!s1_valid || s1_advance);
    rd_addr    = q_data.addr[PIX_AW-1:0];
    wr_addr    = s1.addr[PIX_AW-1:0];
    wr_en      = s1_valid && (s1.kind == OP_PLOT);
    pix        = fwd ? fwd_data : rdata;
    prod_r     = 16'(s1.red) * 16'(s1.weight);
    prod_g     = 16'(s1.green) * 16'(s1.weight);
    prod_b     = 16'(s1.blue) * 16'(s1.weight);
    sum_r      = 9'(pix[23:16]) + 9'(prod_r[15:8]);
    sum_g      = 9'(pix[15:8]) + 9'(prod_g[15:8]);
    sum_b      = 9'(pix[7:0]) + 9'(prod_b[15:8]);
    wr_data    = {sum_r[8] ? 8'hff : sum_r[7:0],
                  sum_g[8] ? 8'hff : sum_g[7:0],
                  sum_b[8] ? 8'hff : sum_b[7:0]};
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clear_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
      s1_valid   <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      if (clear_busy) begin
        clear_addr <= clear_addr + PIX_AW'(1);
        if (clear_addr == PIX_AW'(PIXELS - 1)) begin
          clear_busy <= 1'b0;
        end
      end
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance && (s1.kind == OP_READ)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // A write in the cycle of the read to the same pixel would be missed by the
  // memory, so its data is passed along instead.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1       <= q_data;
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
    if (s1_advance && (s1.kind == OP_READ)) begin
      rsp.red_out   <= s1.hit ? pix[23:16] : 8'h00;
      rsp.green_out <= s1.hit ? pix[15:8] : 8'h00;
      rsp.blue_out  <= s1.hit ? pix[7:0] : 8'h00;
    end
  end

endmodule

>>> rtl/antialiased_subpixel_plot.sv
// ----------------------------------------------------------------------------
// antialiased_subpixel_plot
// Antialiased sub-pixel plotter over an RGB frame store for an LED matrix.
// A plot spreads a color over four neighboring pixels with bilinear weights;
// a read returns one stored pixel.
// ----------------------------------------------------------------------------
// A plot is handled one neighbor at a time by the front end's weight sequencer.
// A read response passes the request registers, the queue, the frame-store read
// register and the response register.
// Reset: the frame store is cleared to black by a pass over every pixel,
// during which req.ready stays low.
// ----------------------------------------------------------------------------
module antialiased_subpixel_plot
  import asp_pkg::*;
#(
  parameter int MATRIX_WIDTH  = MATRIX_WIDTH_DEF,
  parameter int MATRIX_HEIGHT = MATRIX_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  asp_in_if.sink    req,
  asp_out_if.source rsp
);

  logic      clear_busy;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  pixel_op_t q_in;
  pixel_op_t q_out;

  asp_front #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  asp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  asp_back #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .rsp        (rsp),
    .clear_busy (clear_busy),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop)
  );

endmodule

>>> sim/tb_antialiased_subpixel_plot.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_antialiased_subpixel_plot
// Self-checking bench for the antialiased sub-pixel plotter. A queue of plot
// and read requests feeds a bursty driver. A shadow frame store in the bench
// follows every accepted plot, so each read has a known color. The response
// monitor compares every read beat with the oldest predicted color while the
// receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_antialiased_subpixel_plot;
  import asp_pkg::*;

  localparam int MATRIX_W = MATRIX_WIDTH_DEF;
  localparam int MATRIX_H = MATRIX_HEIGHT_DEF;
  localparam int PIXELS   = MATRIX_W * MATRIX_H;

  typedef struct packed {
    op_t         operation;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  pixel_index;
  } request_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  logic clk;
  logic rst;
  logic hold_off = 1'b0;

  asp_in_if  req_if ();
  asp_out_if rsp_if ();

  antialiased_subpixel_plot i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  request_t pending_requests [$];
  rgb_t     expected_colors [$];
  rgb_t     frame_model [PIXELS];
  request_t offered;
  int       accepted_count = 0;
  int       error_count = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_mode_left = 0;
  logic [7:0] rx_pattern = 8'hff;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int corner_weight(input int a, input int b);
    return ((a * b + a + b) >> 8) & 255;
  endfunction

  function automatic logic [7:0] add_clamped(input logic [7:0] base, input int add);
    int sum;
    sum = int'(base) + add;
    return (sum > 255) ? 8'd255 : sum[7:0];
  endfunction

  // Applies one accepted request to the shadow frame store; a read queues its color.
  task automatic record_request(input request_t rq);
    int   frac_x;
    int   frac_y;
    int   col;
    int   row;
    int   addr;
    int   wt [4];
    rgb_t px;
    frac_x = int'(rq.pos_x[7:0]);
    frac_y = int'(rq.pos_y[7:0]);
    if (rq.operation == OP_READ) begin
      if (int'(rq.pixel_index) < PIXELS) begin
        expected_colors.push_back(frame_model[rq.pixel_index]);
      end else begin
        expected_colors.push_back('0);
      end
    end else begin
      wt[0] = corner_weight(255 - frac_x, 255 - frac_y);
      wt[1] = corner_weight(frac_x, 255 - frac_y);
      wt[2] = corner_weight(255 - frac_x, frac_y);
      wt[3] = corner_weight(frac_x, frac_y);
      for (int k = 0; k < 4; k++) begin
        col = int'(rq.pos_x[11:8]) + (k % 2);
        row = int'(rq.pos_y[11:8]) + (k / 2);
        if (col < MATRIX_W && row < MATRIX_H) begin
          addr = row * MATRIX_W + col;
          px = frame_model[addr];
          px.red   = add_clamped(px.red,   (int'(rq.red_in) * wt[k]) >> 8);
          px.green = add_clamped(px.green, (int'(rq.green_in) * wt[k]) >> 8);
          px.blue  = add_clamped(px.blue,  (int'(rq.blue_in) * wt[k]) >> 8);
          frame_model[addr] = px;
        end
      end
    end
  endtask

  function automatic request_t make_request(input op_t op, input int x, input int y,
                                            input int r, input int g, input int b,
                                            input int idx);
    request_t rq;
    rq.operation   = op;
    rq.pos_x       = x[11:0];
    rq.pos_y       = y[11:0];
    rq.red_in      = r[7:0];
    rq.green_in    = g[7:0];
    rq.blue_in     = b[7:0];
    rq.pixel_index = idx[7:0];
    return rq;
  endfunction

  function automatic int random_channel();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
  endfunction

  function automatic int random_position();
    int p;
    p = $urandom_range(0, 4095);
    case ($urandom_range(0, 7))
      0: p[7:0] = 8'h00;
      1: p[7:0] = 8'hff;
      2: p[11:8] = 4'hf;
      default: ;
    endcase
    return p;
  endfunction

  function automatic request_t random_request();
    op_t op;
    op = ($urandom_range(0, 4) < 2) ? OP_READ : OP_PLOT;
    return make_request(op, random_position(), random_position(), random_channel(),
                        random_channel(), random_channel(), $urandom_range(0, 255));
  endfunction

  // Blocks until the sender is idle and every read has returned.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || req_if.valid || expected_colors.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        record_request(offered);
        accepted_count++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
          end
          offered = pending_requests.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
          req_if.valid       <= 1'b1;
          req_if.operation   <= offered.operation;
          req_if.pos_x       <= offered.pos_x;
          req_if.pos_y       <= offered.pos_y;
          req_if.red_in      <= offered.red_in;
          req_if.green_in    <= offered.green_in;
          req_if.blue_in     <= offered.blue_in;
          req_if.pixel_index <= offered.pixel_index;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver stall pattern.
  always @(posedge clk) begin
    rgb_t want;
    logic rdy;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_colors.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Response beat with no read pending: r=%0d g=%0d b=%0d",
                     rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out);
          end
        end else begin
          want = expected_colors.pop_front();
          if (rsp_if.red_out !== want.red || rsp_if.green_out !== want.green ||
              rsp_if.blue_out !== want.blue) begin
            error_count++;
            if (error_count <= 10) begin
              $display("Color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue,
                       rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out);
            end
          end
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
        rx_pattern = 8'($urandom_range(1, 255));
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS: rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default: begin
          rdy = rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
        end
      endcase
      rsp_if.ready <= rdy && !hold_off;
    end
  end

  // Long receiver hold-off while requests keep coming, so the block backs up.
  initial begin
    @(negedge clk);
    while (accepted_count < 60) begin
      @(negedge clk);
    end
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (500) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    req_if.valid       = 1'b0;
    req_if.operation   = OP_PLOT;
    req_if.pos_x       = '0;
    req_if.pos_y       = '0;
    req_if.red_in      = '0;
    req_if.green_in    = '0;
    req_if.blue_in     = '0;
    req_if.pixel_index = '0;
    rsp_if.ready       = 1'b0;
    foreach (frame_model[i]) frame_model[i] = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: black after reset, whole and half weights, clipping at the
    // right and bottom edges and in the corner, saturation, alternating bits.
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(OP_READ, 4095, 4095, 255, 255, 255, 255));
    pending_requests.push_back(make_request(OP_PLOT, 0, 0, 255, 128, 1, 0));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(OP_PLOT, 'h080, 'h080, 200, 100, 50, 0));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 1));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 16));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 17));
    pending_requests.push_back(make_request(OP_PLOT, 'hfff, 'h0ff, 255, 255, 255, 0));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 15));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 31));
    pending_requests.push_back(make_request(OP_PLOT, 'h340, 'hf40, 255, 255, 255, 0));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 243));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 244));
    pending_requests.push_back(make_request(OP_PLOT, 'hfff, 'hfff, 255, 255, 255, 0));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 255));
    repeat (4) pending_requests.push_back(make_request(OP_PLOT, 'h500, 'h500, 255, 255,
                                                       255, 0));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 85));
    pending_requests.push_back(make_request(OP_PLOT, 'haaa, 'h555, 'h55, 'haa, 'h0f, 'hff));
    pending_requests.push_back(make_request(OP_READ, 'h555, 'haaa, 'haa, 'h55, 'hf0, 'h5a));
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 'ha5));
    wait_drained();

    for (int chunk = 0; chunk < 8; chunk++) begin
      repeat (200) pending_requests.push_back(random_request());
      if (chunk % 2 == 1) begin
        wait_drained();
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (error_count == 0 && expected_colors.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
rtl/asp_pkg.sv
rtl/asp_in_if.sv
rtl/asp_out_if.sv
rtl/asp_front.sv
rtl/asp_queue.sv
rtl/asp_back.sv
rtl/antialiased_subpixel_plot.sv
sim/tb_antialiased_subpixel_plot.sv
